// ===== design/pncb_pkg.sv =====
// ---------------------------------------------------------------------------
// pncb_pkg - palette nearest colour blend package
// Shared constants, state codes and arithmetic helpers for the palette core.
// ---------------------------------------------------------------------------
package pncb_pkg;

    // palette geometry
    localparam int PALETTE_DEPTH = 256;
    localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);
    localparam int ADDR_W        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    // field widths
    localparam int CHAN_W   = 8;
    localparam int RGB_W    = 3 * CHAN_W;
    localparam int CMD_W    = 2;
    localparam int STR_W    = 9;
    localparam int DIST_W   = 18;

    // strength settings
    localparam logic [STR_W-1:0] STRENGTH_FULL  = 9'd256;
    localparam logic [STR_W-1:0] STRENGTH_RESET = 9'd256;

    // command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PIXEL = 2'd2;

    // controller state codes
    localparam int ST_W = 2;
    localparam logic [ST_W-1:0] ST_IDLE  = 2'd0;
    localparam logic [ST_W-1:0] ST_SCAN  = 2'd1;
    localparam logic [ST_W-1:0] ST_WRITE = 2'd2;
    localparam logic [ST_W-1:0] ST_OUT   = 2'd3;

    typedef logic [CHAN_W-1:0] t_chan;
    typedef logic [RGB_W-1:0]  t_rgb;
    typedef logic [DIST_W-1:0] t_dist;

    // squared difference of one channel
    function automatic logic [15:0] chan_sq(input t_chan x, input t_chan y);
        logic [7:0] d;
        d = (x > y) ? (x - y) : (y - x);
        return d * d;
    endfunction

    // squared rgb distance between two packed colours
    function automatic t_dist dist_sq(input t_rgb a, input t_rgb b);
        return {2'b00, chan_sq(a[7:0], b[7:0])}
             + {2'b00, chan_sq(a[15:8], b[15:8])}
             + {2'b00, chan_sq(a[23:16], b[23:16])};
    endfunction

    // src + ((pal - src) * s + 128) >> 8, same as the two-weight form
    function automatic t_chan blend_chan(input t_chan src, input t_chan pal,
                                         input logic [STR_W-1:0] s);
        logic signed [8:0]  diff;
        logic signed [19:0] prod;
        logic signed [19:0] v;
        diff = $signed({1'b0, pal}) - $signed({1'b0, src});
        prod = diff * $signed({1'b0, s});
        v    = $signed({4'b0000, src, 8'h00}) + prod + 20'sd128;
        return v[15:8];
    endfunction

endpackage

// ===== design/palette_nearest_color_blend_core.sv =====
// ---------------------------------------------------------------------------
// palette_nearest_color_blend_core - palette nearest colour blend
// Palette store with duplicate-free loading, nearest colour search and
// per-channel blend toward the chosen palette colour.
// ---------------------------------------------------------------------------
// The palette sits in one single-port synchronous RAM of PALETTE_DEPTH
// entries, and both a load beat and a pixel beat walk the valid entries one
// per cycle through that RAM. A pixel beat scans every stored entry before
// its result; transparent pixels, and pixels while the palette is empty,
// skip the scan and go straight to the output stage. A load beat scans for
// a duplicate, then writes; a duplicate is not written, an entry into an
// empty palette is written with no scan; clear needs no scan. New beats are
// accepted only while the controller is idle; a finished result waits in the
// output register, so the next beat can start while it is still not taken.
// Ties in distance go to the entry loaded first. blend_strength above 256 is
// treated as 256.
module palette_nearest_color_blend_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: blend_strength
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_wdata,
    // input beats
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // red, green, blue, alpha
    input  logic [1:0]  s_axis_tuser,   // cmd
    // result beats
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // out_red, out_green, out_blue, out_alpha
    output logic [0:0]  m_axis_tuser    // applied
);
    import pncb_pkg::*;

    // control and configuration
    logic [ST_W-1:0]  r_state;
    logic [CNT_W-1:0] r_count;
    logic [STR_W-1:0] r_strength;

    // captured beat
    logic [CMD_W-1:0] r_cmd;
    t_rgb             r_rgb;
    t_chan            r_alpha;
    logic             r_pass;

    // scan pipeline
    logic [CNT_W-1:0] r_addr;
    logic             r_pend;
    t_rgb             r_rd_data;
    logic             r_dv;
    t_dist            r_dist;
    logic             r_match;
    t_rgb             r_ent;
    logic             r_hit;
    t_dist            r_best_d;
    t_rgb             r_best;

    // output register
    logic             r_out_valid;
    logic [31:0]      r_out_data;
    logic             r_out_applied;

    // palette memory
    t_rgb             r_pal_mem [PALETTE_DEPTH];

    logic             in_beat;
    logic             scan_done;
    logic             out_free;
    logic [STR_W-1:0] s_sat;
    t_chan            bl_red;
    t_chan            bl_green;
    t_chan            bl_blue;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_applied;

    assign scan_done = (r_addr == r_count) && !r_pend && !r_dv;
    assign out_free  = !r_out_valid || m_axis_tready;

    // blend toward the nearest entry
    assign s_sat    = (r_strength > STRENGTH_FULL) ? STRENGTH_FULL : r_strength;
    assign bl_red   = blend_chan(r_rgb[7:0],   r_best[7:0],   s_sat);
    assign bl_green = blend_chan(r_rgb[15:8],  r_best[15:8],  s_sat);
    assign bl_blue  = blend_chan(r_rgb[23:16], r_best[23:16], s_sat);

    // palette ram: one write or one read a cycle, registered read
    always_ff @(posedge i_clk) begin
        if (r_state == ST_WRITE) begin
            r_pal_mem[r_count[ADDR_W-1:0]] <= r_rgb;
        end else begin
            r_rd_data <= r_pal_mem[r_addr[ADDR_W-1:0]];
        end
    end

    // controller, scan pipeline and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_strength  <= STRENGTH_RESET;
            r_pend      <= 1'b0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // configuration write
            if (i_cfg_we) begin
                r_strength <= i_cfg_wdata;
            end

            // result taken downstream, unless a new one takes its place
            if (r_out_valid && m_axis_tready && r_state != ST_OUT) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_beat) begin
                        r_cmd    <= s_axis_tuser;
                        r_rgb    <= s_axis_tdata[23:0];
                        r_alpha  <= s_axis_tdata[31:24];
                        r_addr   <= '0;
                        r_hit    <= 1'b0;
                        r_best_d <= '1;
                        r_pass   <= 1'b0;
                        unique case (s_axis_tuser)
                            CMD_CLEAR: begin
                                r_count <= '0;
                            end
                            CMD_LOAD: begin
                                if (s_axis_tdata[31:24] != '0) begin
                                    if (r_count == '0) begin
                                        r_state <= ST_WRITE;
                                    end else if (r_count < CNT_W'(PALETTE_DEPTH)) begin
                                        r_state <= ST_SCAN;
                                    end
                                end
                            end
                            CMD_PIXEL: begin
                                if (r_count == '0 || s_axis_tdata[31:24] == '0) begin
                                    r_pass  <= 1'b1;
                                    r_state <= ST_OUT;
                                end else begin
                                    r_state <= ST_SCAN;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end

                ST_SCAN: begin
                    // issue one read a cycle
                    if (r_addr < r_count) begin
                        r_pend <= 1'b1;
                        r_addr <= r_addr + 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                    end
                    // distance and match of the returned entry
                    r_dv <= r_pend;
                    if (r_pend) begin
                        r_dist  <= dist_sq(r_rgb, r_rd_data);
                        r_match <= (r_rd_data == r_rgb);
                        r_ent   <= r_rd_data;
                    end
                    // keep the first strictly nearest entry
                    if (r_dv) begin
                        if (r_match) begin
                            r_hit <= 1'b1;
                        end
                        if (r_dist < r_best_d) begin
                            r_best_d <= r_dist;
                            r_best   <= r_ent;
                        end
                    end
                    if (scan_done) begin
                        if (r_cmd == CMD_LOAD) begin
                            r_state <= r_hit ? ST_IDLE : ST_WRITE;
                        end else begin
                            r_state <= ST_OUT;
                        end
                    end
                end

                ST_WRITE: begin
                    r_count <= r_count + 1'b1;
                    r_state <= ST_IDLE;
                end

                ST_OUT: begin
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_applied <= (r_count != '0);
                        if (r_pass) begin
                            r_out_data <= {r_alpha, r_rgb};
                        end else begin
                            r_out_data <= {r_alpha, bl_blue, bl_green, bl_red};
                        end
                        r_state <= ST_IDLE;
                    end
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
